FILE: hdl/svqd_pkg.sv
package svqd_pkg;

  localparam int LaneCount = 4;
  localparam int DataBytes = 16;

  localparam logic [1:0] CodeMask = 2'h3;

  // Length format register codes.
  localparam logic FmtZeroOneTwoFour  = 1'b0;
  localparam logic FmtOneTwoThreeFour = 1'b1;

  typedef logic [2:0] lane_len_t;
  typedef logic [3:0] byte_off_t;
  typedef logic [DataBytes-1:0][7:0] data_bytes_t;

  // Byte length of one lane for a given format and 2-bit code.
  function automatic lane_len_t lane_len(input logic fmt, input logic [1:0] code);
    lane_len_t len;
    if (fmt == FmtOneTwoThreeFour) begin
      len = {1'b0, code} + 3'd1;
    end else begin
      case (code)
        2'd0:    len = 3'd0;
        2'd1:    len = 3'd1;
        2'd2:    len = 3'd2;
        default: len = 3'd4;
      endcase
    end
    return len;
  endfunction

endpackage

FILE: hdl/stream_vbyte_quad_decoder_unit.sv
// Stream VByte group decoder.
// Throughput: one group per cycle; busy is high only during reset.
// Stages: length decode and offsets, byte selection per lane, length masking.
// Reset (synchronous, rst high) clears all in-flight items and length_format.
// The receiver cannot stall, so results are never held back.
module stream_vbyte_quad_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  control_byte,
  input  logic [63:0] data_low,
  input  logic [63:0] data_high,
  input  logic        cfg_write,
  input  logic        cfg_data,
  output logic        done,
  output logic [31:0] value_zero,
  output logic [31:0] value_one,
  output logic [31:0] value_two,
  output logic [31:0] value_three,
  output logic [4:0]  bytes_consumed
);
  import svqd_pkg::*;

  logic length_format;

  logic [2:0] valid;

  lane_len_t [LaneCount-1:0] len_next;
  byte_off_t [LaneCount-1:0] off_next;
  logic [4:0]                total_next;

  lane_len_t [LaneCount-1:0] len_s1;
  byte_off_t [LaneCount-1:0] off_s1;
  data_bytes_t               data_s1;
  logic [4:0]                total_s1;
  logic [4:0]                total_s2;
  logic [4:0]                total_s3;

  logic [LaneCount-1:0][31:0] lane_value;

  logic accept;

  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      length_format <= FmtZeroOneTwoFour;
    end else if (cfg_write) begin
      length_format <= cfg_data;
    end
  end

  // Lane lengths and the running offset at which each lane starts.
  always_comb begin
    logic [4:0] run;
    run = 5'd0;
    for (int i = 0; i < LaneCount; i++) begin
      len_next[i] = lane_len(length_format, control_byte[2*i +: 2] & CodeMask);
      off_next[i] = run[3:0];
      run = run + {2'b00, len_next[i]};
    end
    total_next = run;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[1:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    len_s1   <= len_next;
    off_s1   <= off_next;
    data_s1  <= {data_high, data_low};
    total_s1 <= total_next;
    total_s2 <= total_s1;
    total_s3 <= total_s2;
  end

  for (genvar g = 0; g < LaneCount; g++) begin : g_lane
    svqd_lane u_lane (
      .clk    (clk),
      .data   (data_s1),
      .offset (off_s1[g]),
      .len    (len_s1[g]),
      .value  (lane_value[g])
    );
  end

  assign done           = valid[2];
  assign value_zero     = lane_value[0];
  assign value_one      = lane_value[1];
  assign value_two      = lane_value[2];
  assign value_three    = lane_value[3];
  assign bytes_consumed = total_s3;

endmodule

FILE: hdl/svqd_lane.sv
module svqd_lane (
  input  logic                clk,
  input  svqd_pkg::data_bytes_t data,
  input  svqd_pkg::byte_off_t   offset,
  input  svqd_pkg::lane_len_t   len,
  output logic [31:0]           value
);
  import svqd_pkg::*;

  logic [3:0][7:0] raw;
  lane_len_t       len_d;
  logic [3:0][7:0] raw_next;
  logic [3:0][7:0] masked;

  // Pick four bytes from the running offset; the index wraps inside the group.
  always_comb begin
    byte_off_t idx;
    for (int k = 0; k < 4; k++) begin
      idx = offset + byte_off_t'(k);
      raw_next[k] = data[idx];
    end
  end

  always_ff @(posedge clk) begin
    raw   <= raw_next;
    len_d <= len;
  end

  // Bytes at or above the lane length are not part of the value.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      masked[k] = (lane_len_t'(k) < len_d) ? raw[k] : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    value <= masked;
  end

endmodule

FILE: hdl/svqd_checker.sv
module svqd_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [31:0] value_zero,
  input logic [31:0] value_one,
  input logic [31:0] value_two,
  input logic [31:0] value_three,
  input logic [4:0]  bytes_consumed
);

  // Every accepted item produces a done strobe unless reset intervenes.
  a_item_delivered: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) ##1 !rst ##1 !rst |=> done)
    else $error("accepted item did not produce a result");

  // No result appears without an earlier accepted item.
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 3))
    else $error("result without an accepted item");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> bytes_consumed <= 5'd16)
    else $error("byte count out of range");

  // When no bytes are consumed every lane had zero length.
  a_empty_group: assert property (@(posedge clk) disable iff (rst)
    done && bytes_consumed == 5'd0 |->
      value_zero == 32'd0 && value_one == 32'd0 &&
      value_two == 32'd0 && value_three == 32'd0)
    else $error("nonzero value in an empty group");

endmodule

bind stream_vbyte_quad_decoder_unit svqd_checker u_svqd_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .value_zero     (value_zero),
  .value_one      (value_one),
  .value_two      (value_two),
  .value_three    (value_three),
  .bytes_consumed (bytes_consumed)
);

FILE: dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import svqd_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int PipeDepth = 3;

  typedef struct packed {
    logic [LaneCount-1:0][31:0] lane_value;
    logic [4:0]                 nbytes;
  } group_result_t;

  // Holds the current length format and the decoded groups that are still in flight.
  class group_decode_board;
    logic          fmt;
    group_result_t expected_groups[$];
    int            mismatches;

    function new();
      fmt = FmtZeroOneTwoFour;
      mismatches = 0;
    endfunction

    function void set_format(input logic value);
      fmt = value;
    endfunction

    function int pending_count();
      return expected_groups.size();
    endfunction

    function group_result_t decode_group(input logic [7:0] ctrl, input logic [63:0] lo,
                                         input logic [63:0] hi);
      int unsigned byte_len[2][4] = '{'{0, 1, 2, 4}, '{1, 2, 3, 4}};
      data_bytes_t   bytes;
      group_result_t res;
      logic [1:0]    code;
      int unsigned   len;
      int unsigned   offset;
      bytes = {hi, lo};
      offset = 0;
      for (int lane = 0; lane < LaneCount; lane++) begin
        code = 2'((ctrl >> (2 * lane)) & CodeMask);
        len = byte_len[(fmt == FmtOneTwoThreeFour) ? 1 : 0][code];
        res.lane_value[lane] = '0;
        for (int k = 0; k < len; k++) begin
          res.lane_value[lane] |= 32'(bytes[(offset + k) % DataBytes]) << (8 * k);
        end
        offset += len;
      end
      res.nbytes = 5'(offset);
      return res;
    endfunction

    function void note_group(input logic [7:0] ctrl, input logic [63:0] lo,
                             input logic [63:0] hi);
      expected_groups.push_back(decode_group(ctrl, lo, hi));
    endfunction

    function void check_result(input group_result_t got);
      string         lane_name[LaneCount] = '{"value_zero", "value_one", "value_two",
                                              "value_three"};
      group_result_t exp_res;
      if (expected_groups.size() == 0) begin
        $display("%0t: result with nothing expected: values %h bytes_consumed %0d",
                 $time, got.lane_value, got.nbytes);
        mismatches++;
        return;
      end
      exp_res = expected_groups.pop_front();
      for (int lane = 0; lane < LaneCount; lane++) begin
        if (got.lane_value[lane] !== exp_res.lane_value[lane]) begin
          $display("%0t: %s expected %h actual %h", $time, lane_name[lane],
                   exp_res.lane_value[lane], got.lane_value[lane]);
          mismatches++;
        end
      end
      if (got.nbytes !== exp_res.nbytes) begin
        $display("%0t: bytes_consumed expected %0d actual %0d", $time, exp_res.nbytes,
                 got.nbytes);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [7:0]  control_byte = '0;
  logic [63:0] data_low = '0;
  logic [63:0] data_high = '0;
  logic        cfg_write = 1'b0;
  logic        cfg_data = 1'b0;
  logic        done;
  logic [31:0] value_zero;
  logic [31:0] value_one;
  logic [31:0] value_two;
  logic [31:0] value_three;
  logic [4:0]  bytes_consumed;

  group_decode_board board = new();
  int                cycle_count = 0;

  stream_vbyte_quad_decoder_unit i_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .control_byte   (control_byte),
    .data_low       (data_low),
    .data_high      (data_high),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .done           (done),
    .value_zero     (value_zero),
    .value_one      (value_one),
    .value_two      (value_two),
    .value_three    (value_three),
    .bytes_consumed (bytes_consumed)
  );

  always #6 clk = ~clk;

  // Lane 3 sits in the most significant slot of the packed result.
  always @(posedge clk) begin
    if (done === 1'b1) begin
      board.check_result({value_three, value_two, value_one, value_zero, bytes_consumed});
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("stream_vbyte_quad_decoder_unit test failed");
      $finish;
    end
  end

  // The item stays on the ports until an edge with busy low takes it.
  task automatic send_group(input logic [7:0] ctrl, input logic [63:0] lo,
                            input logic [63:0] hi);
    @(negedge clk);
    start <= 1'b1;
    control_byte <= ctrl;
    data_low <= lo;
    data_high <= hi;
    do @(posedge clk); while (busy !== 1'b0);
    board.note_group(ctrl, lo, hi);
  endtask

  // Garbage on the control byte and the low data word while start is low must be ignored.
  task automatic idle_for(input int cycles);
    @(negedge clk);
    start <= 1'b0;
    control_byte <= 8'($urandom);
    data_low <= {$urandom, $urandom};
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic drain_pipeline();
    @(negedge clk);
    start <= 1'b0;
    while (board.pending_count() != 0) @(posedge clk);
    repeat (PipeDepth + 2) @(posedge clk);
  endtask

  task automatic write_format(input logic value);
    drain_pipeline();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    board.set_format(value);
  endtask

  function automatic logic [63:0] random_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic directed_groups();
    logic [7:0] ctrls[12] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'hE4, 8'h1B,
                              8'h39, 8'hC6, 8'h03, 8'hC0, 8'h0C, 8'h30};
    logic [63:0] seq_lo = 64'h0706050403020100;
    logic [63:0] seq_hi = 64'h0F0E0D0C0B0A0908;
    for (int i = 0; i < 12; i++) begin
      if (i == 0) begin
        send_group(ctrls[i], '1, '1);
      end else if (i == 1) begin
        send_group(ctrls[i], '0, '0);
      end else if (i % 2 == 0) begin
        send_group(ctrls[i], seq_lo, seq_hi);
      end else begin
        send_group(ctrls[i], ~seq_lo, ~seq_hi);
      end
    end
  endtask

  task automatic random_groups(input int count, input bit with_gaps);
    int stretch_left = 0;
    bit gaps_now = 1'b0;
    for (int i = 0; i < count; i++) begin
      if (stretch_left == 0) begin
        stretch_left = $urandom_range(20, 60);
        gaps_now = with_gaps && ($urandom_range(0, 1) == 1);
      end
      stretch_left--;
      if (gaps_now && $urandom_range(0, 3) == 0) begin
        idle_for($urandom_range(1, 14));
      end
      send_group(8'($urandom), random_word(), random_word());
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // The reset format is used first, without any write.
    directed_groups();
    write_format(FmtOneTwoThreeFour);
    directed_groups();

    random_groups(300, 1'b1);
    write_format(FmtZeroOneTwoFour);
    random_groups(300, 1'b1);
    write_format(FmtZeroOneTwoFour);
    random_groups(300, 1'b1);
    write_format(FmtOneTwoThreeFour);
    random_groups(300, 1'b1);
    write_format(FmtZeroOneTwoFour);
    random_groups(300, 1'b1);
    write_format(FmtOneTwoThreeFour);
    random_groups(230, 1'b0);

    drain_pipeline();
    if (board.mismatches == 0 && board.pending_count() == 0) begin
      $display("stream_vbyte_quad_decoder_unit test passed");
    end else begin
      $display("stream_vbyte_quad_decoder_unit test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/svqd_pkg.sv
hdl/svqd_lane.sv
hdl/stream_vbyte_quad_decoder_unit.sv
hdl/svqd_checker.sv
dv/tb_top.sv
